// ===== rtl/per_user_fixed_window_rate_limiter_assert.svh =====
// Assertion macros for the per-user rate limiter checker.
// Included by the checker file; needs no other file.
`ifndef PER_USER_FIXED_WINDOW_RATE_LIMITER_ASSERT_SVH
`define PER_USER_FIXED_WINDOW_RATE_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define PUFWRL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rate limiter assertion failed");

// Next-cycle implication, disabled while reset is low
`define PUFWRL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rate limiter assertion failed");

`endif

// ===== rtl/pufwrl_pkg.sv =====
// Shared types and constants of the per-user rate limiter.
// Used by the top level and its checker; depends on nothing.
`default_nettype none

package pufwrl_pkg;

    // Default sizes
    localparam int DEF_MAX_USERS = 16;
    localparam int DEF_ID_BITS   = 16;

    // Field and register widths
    localparam int UID_W      = 16;
    localparam int TOK_W      = 8;
    localparam int CD_W       = 16;
    localparam int STAT_W     = 3;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_PERIOD   = 4'd1;

    // Register reset values
    localparam logic [TOK_W-1:0] CAP_RESET    = 8'd4;
    localparam logic [CD_W-1:0]  PERIOD_RESET = 16'd60;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd4;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_JOIN    = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_REQUEST = 2'd3
    } op_t;

    typedef struct packed {
        op_t              req_type;
        logic [UID_W-1:0] user_id;
    } pufwrl_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [TOK_W-1:0]     tokens_left;
        logic [CNT_OUT_W-1:0] user_count;
    } pufwrl_out_t;

endpackage

`default_nettype wire

// ===== rtl/pufwrl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
`default_nettype none

module pufwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/per_user_fixed_window_rate_limiter.sv =====
// Per-user fixed-window rate limiter. A table of MAX_USERS entries holds each
// user's id, token count and refill countdown in one RAM. Every item (tick,
// join, remove, request) walks the whole table once through a single entry
// update/compare unit, one entry per cycle; a tick rewrites each valid entry
// as it passes, any other item then commits at most one write. Every item
// then loads the result register. The steps in order: the accept, the table
// walk through the single RAM read port (reads run one entry ahead of the
// entry unit and are drained at the end), the update and the load of the
// result register. The load waits while an earlier result still waits in
// the result register. The result register lets the next input transfer in
// while a result waits. After reset a clearing pass empties the table; no
// input is taken until it ends, but register writes are taken at any time.
// Depends on pufwrl_pkg and pufwrl_ram.
`default_nettype none

module per_user_fixed_window_rate_limiter #(
    parameter int MAX_USERS = pufwrl_pkg::DEF_MAX_USERS,
    parameter int ID_BITS   = pufwrl_pkg::DEF_ID_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire pufwrl_pkg::pufwrl_in_t               s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output pufwrl_pkg::pufwrl_out_t                   m_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [pufwrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pufwrl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pufwrl_pkg::*;

    localparam int IDX_W   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CTR_W   = IDX_W + 1;
    localparam int CNT_W   = $clog2(MAX_USERS + 1);
    localparam int ENTRY_W = 1 + ID_BITS + TOK_W + CD_W;

    typedef struct packed {
        logic               vld;
        logic [ID_BITS-1:0] id;
        logic [TOK_W-1:0]   tok;
        logic [CD_W-1:0]    cd;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic [CTR_W-1:0]   ctr_reg, ctr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    entry_t             hit_ent_reg, hit_ent_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOK_W-1:0]   cap_reg, cap_next;
    logic [CD_W-1:0]    period_reg, period_next;
    pufwrl_out_t        res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    pufwrl_out_t        m_data_reg, m_data_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_ent;
    logic [31:0]        id_ext;

    assign rd_ent    = ram_rdata;
    assign id_ext    = 32'(s_data.user_id);
    assign ram_raddr = ctr_reg[IDX_W-1:0];

    pufwrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_USERS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Sequencer and entry unit
    always_comb begin
        entry_t           upd_ent;
        logic [CNT_W-1:0] cnt_new;
        logic [31:0]      cnt_wide;

        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        ctr_next      = ctr_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_ent_next  = hit_ent_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        period_next   = period_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = pend_idx_reg;
        ram_wdata     = '0;
        upd_ent       = rd_ent;
        cnt_new       = count_reg;
        cnt_wide      = 32'(count_reg);

        // Take register writes at any time
        if (cfg_valid) begin
            if (cfg_index == REG_BUCKET_CAPACITY) begin
                cap_next = cfg_data[TOK_W-1:0];
            end else if (cfg_index == REG_REFILL_PERIOD) begin
                period_next = cfg_data[CD_W-1:0];
            end
        end

        // Drop the result once transferred
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // Clear one entry per cycle
                ram_we    = 1'b1;
                ram_waddr = ctr_reg[IDX_W-1:0];
                ram_wdata = '0;
                if (ctr_reg == CTR_W'(MAX_USERS - 1)) begin
                    ctr_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.req_type;
                    key_next   = id_ext[ID_BITS-1:0];
                    ctr_next   = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN: begin
                // Issue the next read
                if (ctr_reg != CTR_W'(MAX_USERS)) begin
                    ctr_next      = ctr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = ctr_reg[IDX_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end

                // Process the entry read last cycle
                if (pend_reg) begin
                    if (op_reg == OP_TICK) begin
                        if (rd_ent.vld) begin
                            if (rd_ent.cd <= CD_W'(1)) begin
                                upd_ent.tok = cap_reg;
                                upd_ent.cd  = period_reg;
                            end else begin
                                upd_ent.cd = rd_ent.cd - 1'b1;
                            end
                            ram_we    = 1'b1;
                            ram_waddr = pend_idx_reg;
                            ram_wdata = upd_ent;
                        end
                    end else begin
                        if (rd_ent.vld && (rd_ent.id == key_reg) && !hit_reg) begin
                            hit_next     = 1'b1;
                            hit_idx_next = pend_idx_reg;
                            hit_ent_next = rd_ent;
                        end
                        if (!rd_ent.vld && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                    end
                end

                if ((ctr_reg == CTR_W'(MAX_USERS)) && !pend_reg) begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE: begin
                res_next.status      = STAT_OK;
                res_next.tokens_left = '0;
                unique case (op_reg)
                    OP_TICK: begin
                    end
                    OP_JOIN: begin
                        if (hit_reg) begin
                            res_next.status = STAT_DUPLICATE;
                        end else if (!free_reg) begin
                            res_next.status = STAT_FULL;
                        end else begin
                            upd_ent.vld = 1'b1;
                            upd_ent.id  = key_reg;
                            upd_ent.tok = cap_reg;
                            upd_ent.cd  = period_reg;
                            ram_we      = 1'b1;
                            ram_waddr   = free_idx_reg;
                            ram_wdata   = upd_ent;
                            cnt_new     = count_reg + 1'b1;
                            res_next.tokens_left = cap_reg;
                        end
                    end
                    OP_REMOVE: begin
                        if (!hit_reg) begin
                            res_next.status = STAT_NOT_FOUND;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_idx_reg;
                            ram_wdata = '0;
                            if (count_reg != '0) begin
                                cnt_new = count_reg - 1'b1;
                            end
                        end
                    end
                    OP_REQUEST: begin
                        if (!hit_reg) begin
                            res_next.status = STAT_NOT_FOUND;
                        end else if (hit_ent_reg.tok != '0) begin
                            upd_ent     = hit_ent_reg;
                            upd_ent.tok = hit_ent_reg.tok - 1'b1;
                            ram_we      = 1'b1;
                            ram_waddr   = hit_idx_reg;
                            ram_wdata   = upd_ent;
                            res_next.tokens_left = upd_ent.tok;
                        end else begin
                            res_next.status = STAT_REFUSED;
                        end
                    end
                    default: begin
                    end
                endcase
                cnt_wide            = 32'(cnt_new);
                count_next          = cnt_new;
                res_next.user_count = cnt_wide[CNT_OUT_W-1:0];
                state_next          = S_DONE;
            end

            S_DONE: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            ctr_reg     <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            period_reg  <= PERIOD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ctr_reg      <= ctr_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            period_reg   <= period_next;
            m_valid_reg  <= m_valid_next;
            op_reg       <= op_next;
            key_reg      <= key_next;
            pend_idx_reg <= pend_idx_next;
            hit_idx_reg  <= hit_idx_next;
            hit_ent_reg  <= hit_ent_next;
            free_idx_reg <= free_idx_next;
            res_reg      <= res_next;
            m_data_reg   <= m_data_next;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pufwrl_checker.sv =====
// Port-level checker for the per-user rate limiter, bound to the top level.
// Depends on pufwrl_pkg and the assertion macro header.
`default_nettype none

`include "per_user_fixed_window_rate_limiter_assert.svh"

module pufwrl_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire pufwrl_pkg::pufwrl_in_t            s_data,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire pufwrl_pkg::pufwrl_out_t           m_data,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [pufwrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [pufwrl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pufwrl_pkg::*;

    // A stalled result holds
    `PUFWRL_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // The table walk keeps the input closed after a transfer
    `PUFWRL_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A new result only comes out of a busy cycle
    `PUFWRL_ASSERT_IMP(a_result_from_work, aclk, aresetn, $rose(m_valid), $past(!s_ready))

    // Failed operations report no tokens
    `PUFWRL_ASSERT_IMP(a_err_no_tokens, aclk, aresetn, m_valid && (m_data.status == STAT_REFUSED || m_data.status == STAT_NOT_FOUND || m_data.status == STAT_FULL || m_data.status == STAT_DUPLICATE), m_data.tokens_left == '0)

endmodule

bind per_user_fixed_window_rate_limiter pufwrl_checker u_pufwrl_checker (.*);

`default_nettype wire

// ===== dv/per_user_fixed_window_rate_limiter_checker.sv =====
// Checker for the per-user rate limiter: watches the input, result and register
// write channels, keeps its own copy of the user table and scores every result.
// Depends on pufwrl_pkg.
`default_nettype none

module per_user_fixed_window_rate_limiter_checker
    import pufwrl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire pufwrl_in_t            s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire pufwrl_out_t           m_data,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned                mismatch_count,
    output int unsigned                outcomes_pending
);

    localparam int MAX_USERS = DEF_MAX_USERS;
    localparam logic [UID_W-1:0] ID_MASK =
        (DEF_ID_BITS >= UID_W) ? {UID_W{1'b1}} : UID_W'((64'd1 << DEF_ID_BITS) - 64'd1);

    // Shadow of the user table and the two registers
    bit             slot_used [MAX_USERS];
    bit [UID_W-1:0] slot_id   [MAX_USERS];
    bit [TOK_W-1:0] slot_tok  [MAX_USERS];
    bit [CD_W-1:0]  slot_cd   [MAX_USERS];
    int unsigned    user_total;
    bit [TOK_W-1:0] capacity;
    bit [CD_W-1:0]  period;

    pufwrl_out_t outcome_q[$];
    int unsigned errors;

    // Apply one item to the shadow table and return the result it should give
    function automatic pufwrl_out_t limiter_outcome(input pufwrl_in_t item);
        pufwrl_out_t      res;
        logic [UID_W-1:0] uid;
        int               hit;
        int               free_slot;
        res = '0;
        res.status = STAT_OK;
        uid = item.user_id & ID_MASK;
        hit = -1;
        free_slot = -1;
        // scan downward so the lowest matching and lowest free entries win
        for (int i = MAX_USERS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_id[i] == uid) hit = i;
            if (!slot_used[i]) free_slot = i;
        end
        case (item.req_type)
            OP_TICK: begin
                for (int i = 0; i < MAX_USERS; i++) begin
                    if (slot_used[i]) begin
                        if (slot_cd[i] <= 1) begin
                            slot_tok[i] = capacity;
                            slot_cd[i] = period;
                        end else begin
                            slot_cd[i] = slot_cd[i] - 1'b1;
                        end
                    end
                end
            end
            OP_JOIN: begin
                if (hit >= 0) begin
                    res.status = STAT_DUPLICATE;
                end else if (free_slot < 0) begin
                    res.status = STAT_FULL;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_id[free_slot] = uid;
                    slot_tok[free_slot] = capacity;
                    slot_cd[free_slot] = period;
                    user_total++;
                    res.tokens_left = capacity;
                end
            end
            OP_REMOVE: begin
                if (hit < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    slot_used[hit] = 1'b0;
                    if (user_total > 0) user_total--;
                end
            end
            default: begin
                if (hit < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else if (slot_tok[hit] > 0) begin
                    slot_tok[hit] = slot_tok[hit] - 1'b1;
                    res.tokens_left = slot_tok[hit];
                end else begin
                    res.status = STAT_REFUSED;
                end
            end
        endcase
        res.user_count = CNT_OUT_W'(user_total);
        return res;
    endfunction

    always @(posedge aclk) begin
        pufwrl_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_USERS; i++) begin
                slot_used[i] = 1'b0;
                slot_id[i] = '0;
                slot_tok[i] = '0;
                slot_cd[i] = '0;
            end
            user_total = 0;
            capacity = CAP_RESET;
            period = PERIOD_RESET;
            outcome_q.delete();
            errors = 0;
        end else begin
            // register write transfer; unmapped indexes change nothing
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_BUCKET_CAPACITY) capacity = cfg_data[TOK_W-1:0];
                else if (cfg_index == REG_REFILL_PERIOD) period = cfg_data[CD_W-1:0];
            end
            // score the result transfer against the oldest expectation first
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h", $time, m_data);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.tokens_left !== want.tokens_left) begin
                        $display("%0t: tokens_left mismatch: expected %0d, got %0d",
                                 $time, want.tokens_left, m_data.tokens_left);
                        errors++;
                    end
                    if (m_data.user_count !== want.user_count) begin
                        $display("%0t: user_count mismatch: expected %0d, got %0d",
                                 $time, want.user_count, m_data.user_count);
                        errors++;
                    end
                end
            end
            // predict the input transfer and append it behind the others
            if (s_valid && s_ready) outcome_q = {outcome_q, limiter_outcome(s_data)};
        end
        mismatch_count <= errors;
        outcomes_pending <= outcome_q.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb_per_user_fixed_window_rate_limiter.sv =====
// Testbench top for the per-user rate limiter: clock, reset, stimulus and verdict.
// Depends on pufwrl_pkg, the block itself and per_user_fixed_window_rate_limiter_checker.
`default_nettype none

module tb_per_user_fixed_window_rate_limiter;
    import pufwrl_pkg::*;

    localparam int ID_POOL_SIZE = 24;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int SETTLE_CYCLES = DEF_MAX_USERS + 12;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pufwrl_in_t            s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pufwrl_out_t           m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned outcomes_pending;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic [UID_W-1:0] id_pool [ID_POOL_SIZE];

    per_user_fixed_window_rate_limiter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    per_user_fixed_window_rate_limiter_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .outcomes_pending (outcomes_pending)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Stall the result channel at the current rate
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Offer one item after a random idle stretch and hold it until the transfer
    task automatic send_item(input op_t op, input logic [UID_W-1:0] id);
        pufwrl_in_t item;
        item.req_type = op;
        item.user_id = id;
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and hold off until every expected result has arrived
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outcomes_pending != 0) @(negedge aclk);
    endtask

    // Write one register and hold it until the transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ids from a small pool so users get hit, now and then a stray id
    function automatic pufwrl_in_t random_item();
        pufwrl_in_t  item;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) item.req_type = OP_TICK;
        else if (roll < 45) item.req_type = OP_JOIN;
        else if (roll < 65) item.req_type = OP_REMOVE;
        else item.req_type = OP_REQUEST;
        if (item.req_type == OP_TICK || $urandom_range(19) == 0) item.user_id = UID_W'($urandom);
        else item.user_id = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
        return item;
    endfunction

    initial begin : stimulus
        pufwrl_in_t  item;
        logic [CFG_DATA_W-1:0] cap_val;
        logic [CFG_DATA_W-1:0] period_val;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL_SIZE; i++) id_pool[i] = UID_W'($urandom);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset register values, duplicate join, unknown users
        send_item(OP_JOIN, 16'h0000);
        send_item(OP_JOIN, 16'h0000);
        send_item(OP_REQUEST, 16'hFFFF);
        send_item(OP_REMOVE, 16'hFFFF);
        send_item(OP_REQUEST, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_REMOVE, 16'h0000);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_BUCKET_CAPACITY, 16'd2);
        write_reg(REG_REFILL_PERIOD, 16'd2);

        // Directed: spend the bucket, decrement then refill on ticks
        send_item(OP_JOIN, 16'hFFFF);
        send_item(OP_REQUEST, 16'hFFFF);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_REQUEST, 16'hFFFF);
        send_item(OP_REQUEST, 16'hFFFF);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_REQUEST, 16'hFFFF);

        // Directed: fill the table, then a full join and a duplicate while full
        for (int i = 1; i < DEF_MAX_USERS; i++) send_item(OP_JOIN, UID_W'(i));
        send_item(OP_JOIN, 16'h1234);
        send_item(OP_JOIN, 16'hFFFF);

        // Random phases, each with its own register setting and idling mix
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(negedge aclk);
            case (p)
                0: begin
                    cap_val = '1; period_val = '1; tx_idle_pct = 0; rx_stall_pct = 0;
                    write_reg(REG_UNMAPPED_HI, '1);
                end
                1: begin
                    cap_val = 16'd1; period_val = 16'd1; tx_idle_pct = 50; rx_stall_pct = 0;
                end
                2: begin
                    cap_val = 16'd0; period_val = 16'd0; tx_idle_pct = 0; rx_stall_pct = 50;
                end
                3: begin
                    cap_val = 16'd3; period_val = 16'd3; tx_idle_pct = 23; rx_stall_pct = 23;
                end
                4: begin
                    cap_val = CFG_DATA_W'(CAP_RESET); period_val = PERIOD_RESET;
                    tx_idle_pct = 0; rx_stall_pct = 0;
                    write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
                end
                5: begin
                    cap_val = CFG_DATA_W'($urandom_range(255, 1));
                    period_val = CFG_DATA_W'($urandom_range(8, 1));
                    tx_idle_pct = 50; rx_stall_pct = 0;
                end
                6: begin
                    cap_val = CFG_DATA_W'($urandom_range(255, 1));
                    period_val = CFG_DATA_W'($urandom_range(65535, 1));
                    tx_idle_pct = 0; rx_stall_pct = 50;
                end
                default: begin
                    cap_val = 16'd2; period_val = 16'd2; tx_idle_pct = 23; rx_stall_pct = 23;
                end
            endcase
            write_reg(REG_BUCKET_CAPACITY, cap_val);
            write_reg(REG_REFILL_PERIOD, period_val);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender once mid-phase until the result channel runs dry
                if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
                item = random_item();
                send_item(item.req_type, item.user_id);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && outcomes_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
